### hw/rtl/ibx_pkg.sv
// Shared types, codes and constants for the integer/branch execute unit.
// No dependencies; ibx_regfile, ibx_exec and the top level refer to this package by scope.
package ibx_pkg;

    localparam int XLEN      = 64;
    localparam int REG_COUNT = 31;
    localparam int REG_AW    = 5;

    localparam logic [REG_AW-1:0] REG_ZR   = 5'd31;
    localparam logic [REG_AW-1:0] REG_LINK = 5'd30;

    // op_flags bit positions
    localparam int FL_W64  = 0;
    localparam int FL_SUB  = 1;
    localparam int FL_SETF = 2;
    localparam int FL_REG  = 5;
    localparam int FL_MOVN = 6;
    localparam int FL_INV  = 7;

    localparam logic [XLEN-1:0] MASK32    = 64'h0000_0000_ffff_ffff;
    localparam logic [XLEN-1:0] HALF_MASK = 64'h0000_0000_0000_ffff;
    localparam logic [XLEN-1:0] PC_STEP   = 64'd4;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    localparam int S_TDATA_W = 104;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 144;
    localparam int M_TUSER_W = 3;

    typedef enum logic [2:0] {
        FUNC_ADDSUB = 3'd0,
        FUNC_BCOND  = 3'd1,
        FUNC_CBZ    = 3'd2,
        FUNC_B      = 3'd3,
        FUNC_MOVW   = 3'd4,
        FUNC_LOGIC  = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_GP   = 2'd1,
        KIND_SP   = 2'd2
    } t_dest_kind;

    typedef enum logic [1:0] {
        LOP_AND = 2'd0,
        LOP_ORR = 2'd1,
        LOP_EOR = 2'd2,
        LOP_BAD = 2'd3
    } t_logic_op;

    typedef enum logic [3:0] {
        SH_LSL = 4'd0,
        SH_LSR = 4'd1,
        SH_ASR = 4'd2,
        SH_ROR = 4'd3
    } t_shift;

    typedef enum logic [3:0] {
        COND_EQ = 4'd0,
        COND_NE = 4'd1,
        COND_CS = 4'd2,
        COND_CC = 4'd3,
        COND_MI = 4'd4,
        COND_PL = 4'd5,
        COND_VS = 4'd6,
        COND_VC = 4'd7,
        COND_HI = 4'd8,
        COND_LS = 4'd9,
        COND_GE = 4'd10,
        COND_LT = 4'd11,
        COND_GT = 4'd12,
        COND_LE = 4'd13,
        COND_AL = 4'd14,
        COND_NV = 4'd15
    } t_cond;

    typedef struct packed {
        t_func              func;
        logic [4:0]         dest_reg;
        logic [4:0]         src_reg_a;
        logic [4:0]         src_reg_b;
        logic [7:0]         op_flags;
        logic [5:0]         amount;
        t_logic_op          logic_op;
        logic [3:0]         cond_or_shift;
        logic signed [63:0] immediate;
    } t_item;

    typedef struct packed {
        logic [63:0] next_pc;
        t_dest_kind  dest_kind;
        logic [4:0]  dest_index;
        logic [63:0] dest_value;
        logic [3:0]  nzcv;
        logic        status;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [REG_AW-1:0] addr;
        logic [XLEN-1:0]   data;
    } t_rf_write;

    typedef struct packed {
        logic              re;
        logic [REG_AW-1:0] addr_a;
        logic [REG_AW-1:0] addr_b;
    } t_rf_read;

    // Clip to the low word for 32-bit forms
    function automatic logic [XLEN-1:0] fit(input logic [XLEN-1:0] v, input logic w64);
        return w64 ? v : (v & MASK32);
    endfunction

endpackage

### hw/rtl/ibx_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module ibx_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q_a;
    logic [WIDTH-1:0] r_q_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q_a <= r_mem[i_raddr_a];
            r_q_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_q_a;
    assign o_rdata_b = r_q_b;

endmodule

### hw/rtl/ibx_regfile.sv
// General register file: RAM storage, per-entry valid bits and write bypass.
// Depends on ibx_pkg and ibx_ram.
module ibx_regfile (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ibx_pkg::t_rf_read      i_rd,
    input  ibx_pkg::t_rf_write     i_wr,
    output logic [ibx_pkg::XLEN-1:0] o_rdata_a,
    output logic [ibx_pkg::XLEN-1:0] o_rdata_b
);

    logic [ibx_pkg::REG_COUNT-1:0] r_valid;
    logic [ibx_pkg::XLEN-1:0]      ram_a;
    logic [ibx_pkg::XLEN-1:0]      ram_b;
    logic [ibx_pkg::XLEN-1:0]      r_wdata;
    logic                          r_zero_a, r_zero_b;
    logic                          r_byp_a, r_byp_b;
    logic                          r_hit_a, r_hit_b;
    logic                          zero_a, zero_b;
    logic                          vld_a, vld_b;

    ibx_ram #(
        .WIDTH (ibx_pkg::XLEN),
        .DEPTH (ibx_pkg::REG_COUNT)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (i_wr.we),
        .i_waddr   (i_wr.addr),
        .i_wdata   (i_wr.data),
        .i_re      (i_rd.re),
        .i_raddr_a (i_rd.addr_a),
        .i_raddr_b (i_rd.addr_b),
        .o_rdata_a (ram_a),
        .o_rdata_b (ram_b)
    );

    assign zero_a = (i_rd.addr_a == ibx_pkg::REG_ZR);
    assign zero_b = (i_rd.addr_b == ibx_pkg::REG_ZR);
    assign vld_a  = zero_a ? 1'b0 : r_valid[i_rd.addr_a];
    assign vld_b  = zero_b ? 1'b0 : r_valid[i_rd.addr_b];

    // Entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.we) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    // Capture read side; forward a write landing on the same edge
    always_ff @(posedge i_clk) begin
        if (i_rd.re) begin
            r_zero_a <= zero_a;
            r_zero_b <= zero_b;
            r_byp_a  <= i_wr.we && (i_wr.addr == i_rd.addr_a);
            r_byp_b  <= i_wr.we && (i_wr.addr == i_rd.addr_b);
            r_hit_a  <= vld_a;
            r_hit_b  <= vld_b;
            r_wdata  <= i_wr.data;
        end
    end

    assign o_rdata_a = r_zero_a ? '0 : r_byp_a ? r_wdata : r_hit_a ? ram_a : '0;
    assign o_rdata_b = r_zero_b ? '0 : r_byp_b ? r_wdata : r_hit_b ? ram_b : '0;

endmodule

### hw/rtl/ibx_exec.sv
// Combinational execute stage: add/sub, branches, move wide and shifted logic.
// Depends on ibx_pkg only.
module ibx_exec (
    input  ibx_pkg::t_item           i_item,
    input  logic [ibx_pkg::XLEN-1:0] i_reg_a,
    input  logic [ibx_pkg::XLEN-1:0] i_reg_b,
    input  logic [ibx_pkg::XLEN-1:0] i_pc,
    input  logic [ibx_pkg::XLEN-1:0] i_sp,
    input  logic [3:0]               i_nzcv,
    output ibx_pkg::t_result         o_res
);

    always_comb begin
        logic        w64, sub, setf, regf, wfit;
        logic        cond_ok, n_f, z_f, c_f, v_f, carry, ovf, taken;
        logic        gp_en, sp_en;
        logic [4:0]  widx;
        logic [5:0]  amt;
        logic [63:0] a_zr, a_sp, b_zr, l, r, rr, res, vbits, wval, imm;
        logic [63:0] sh, opnd, lres;
        logic [63:0] sh_lsl64, sh_lsr64, sh_asr64;
        logic [31:0] sh_lsl32, sh_lsr32, sh_asr32, sh_ror32;
        logic signed [31:0] asr32_s;
        logic [63:0] rot32_w, rot64;
        logic [127:0] rot64_w;
        logic [64:0] sum65;
        logic [32:0] sum33;

        w64   = i_item.op_flags[ibx_pkg::FL_W64];
        sub   = i_item.op_flags[ibx_pkg::FL_SUB];
        setf  = i_item.op_flags[ibx_pkg::FL_SETF];
        regf  = i_item.op_flags[ibx_pkg::FL_REG];
        amt   = i_item.amount;
        imm   = i_item.immediate;
        wfit  = w64;

        a_zr = ibx_pkg::fit(i_reg_a, w64);
        a_sp = ibx_pkg::fit((i_item.src_reg_a == ibx_pkg::REG_ZR) ? i_sp : i_reg_a, w64);
        b_zr = ibx_pkg::fit(i_reg_b, w64);

        // Add/sub datapath
        l     = regf ? a_zr : a_sp;
        r     = regf ? b_zr : ibx_pkg::fit(imm, w64);
        rr    = sub ? ~r : r;
        sum65 = {1'b0, l} + {1'b0, rr} + {64'd0, sub};
        sum33 = {1'b0, l[31:0]} + {1'b0, rr[31:0]} + {32'd0, sub};
        res   = ibx_pkg::fit(sum65[63:0], w64);
        carry = w64 ? sum65[64] : sum33[32];
        vbits = sub ? ((l ^ r) & (l ^ res)) : (~(l ^ r) & (l ^ res));
        ovf   = w64 ? vbits[63] : vbits[31];

        // Condition evaluation
        n_f = i_nzcv[3];
        z_f = i_nzcv[2];
        c_f = i_nzcv[1];
        v_f = i_nzcv[0];
        case (ibx_pkg::t_cond'(i_item.cond_or_shift))
            ibx_pkg::COND_EQ: cond_ok = z_f;
            ibx_pkg::COND_NE: cond_ok = !z_f;
            ibx_pkg::COND_CS: cond_ok = c_f;
            ibx_pkg::COND_CC: cond_ok = !c_f;
            ibx_pkg::COND_MI: cond_ok = n_f;
            ibx_pkg::COND_PL: cond_ok = !n_f;
            ibx_pkg::COND_VS: cond_ok = v_f;
            ibx_pkg::COND_VC: cond_ok = !v_f;
            ibx_pkg::COND_HI: cond_ok = c_f && !z_f;
            ibx_pkg::COND_LS: cond_ok = !c_f || z_f;
            ibx_pkg::COND_GE: cond_ok = (n_f == v_f);
            ibx_pkg::COND_LT: cond_ok = (n_f != v_f);
            ibx_pkg::COND_GT: cond_ok = !z_f && (n_f == v_f);
            ibx_pkg::COND_LE: cond_ok = z_f || (n_f != v_f);
            default:          cond_ok = 1'b1;
        endcase

        // Shifter for the second logical operand
        sh_lsl64 = b_zr << amt;
        sh_lsr64 = b_zr >> amt;
        sh_asr64 = $signed(b_zr) >>> amt;
        rot64_w  = {b_zr, b_zr} >> amt;
        rot64    = rot64_w[63:0];
        sh_lsl32 = amt[5] ? 32'd0 : (b_zr[31:0] << amt[4:0]);
        sh_lsr32 = amt[5] ? 32'd0 : (b_zr[31:0] >> amt[4:0]);
        // Keep the arithmetic shift out of the unsigned select
        asr32_s  = $signed(b_zr[31:0]) >>> amt[4:0];
        sh_asr32 = amt[5] ? {32{b_zr[31]}} : asr32_s;
        rot32_w  = {b_zr[31:0], b_zr[31:0]} >> amt[4:0];
        sh_ror32 = rot32_w[31:0];
        case (ibx_pkg::t_shift'(i_item.cond_or_shift))
            ibx_pkg::SH_LSL: sh = w64 ? sh_lsl64 : {32'd0, sh_lsl32};
            ibx_pkg::SH_LSR: sh = w64 ? sh_lsr64 : {32'd0, sh_lsr32};
            ibx_pkg::SH_ASR: sh = w64 ? sh_asr64 : {32'd0, sh_asr32};
            ibx_pkg::SH_ROR: sh = w64 ? rot64    : {32'd0, sh_ror32};
            default:         sh = b_zr;
        endcase
        opnd = i_item.op_flags[ibx_pkg::FL_INV] ? ~sh : sh;
        case (i_item.logic_op)
            ibx_pkg::LOP_AND: lres = ibx_pkg::fit(a_zr & opnd, w64);
            ibx_pkg::LOP_ORR: lres = ibx_pkg::fit(a_zr | opnd, w64);
            default:          lres = ibx_pkg::fit(a_zr ^ opnd, w64);
        endcase

        o_res.next_pc = i_pc + ibx_pkg::PC_STEP;
        o_res.nzcv    = i_nzcv;
        o_res.status  = ibx_pkg::STATUS_OK;
        gp_en = 1'b0;
        sp_en = 1'b0;
        widx  = i_item.dest_reg;
        wval  = '0;
        taken = 1'b0;

        case (i_item.func)
            ibx_pkg::FUNC_ADDSUB: begin
                wval = res;
                if (setf) begin
                    o_res.nzcv = {(w64 ? res[63] : res[31]), (res == '0), carry, ovf};
                    gp_en = (i_item.dest_reg != ibx_pkg::REG_ZR);
                end else if (i_item.dest_reg == ibx_pkg::REG_ZR) begin
                    sp_en = 1'b1;
                end else begin
                    gp_en = 1'b1;
                end
            end
            ibx_pkg::FUNC_BCOND: begin
                o_res.next_pc = i_pc + (cond_ok ? imm : ibx_pkg::PC_STEP);
            end
            ibx_pkg::FUNC_CBZ: begin
                taken = (b_zr == '0) != regf;
                o_res.next_pc = i_pc + (taken ? imm : ibx_pkg::PC_STEP);
            end
            ibx_pkg::FUNC_B: begin
                // Link register always takes the full 64-bit return address
                gp_en = regf;
                widx  = ibx_pkg::REG_LINK;
                wval  = i_pc + ibx_pkg::PC_STEP;
                wfit  = 1'b1;
                o_res.next_pc = i_pc + imm;
            end
            ibx_pkg::FUNC_MOVW: begin
                if (regf) begin
                    wval = (a_zr & ~(ibx_pkg::HALF_MASK << amt)) | imm;
                end else if (i_item.op_flags[ibx_pkg::FL_MOVN]) begin
                    wval = ~imm;
                end else begin
                    wval = imm;
                end
                gp_en = (i_item.dest_reg != ibx_pkg::REG_ZR);
            end
            ibx_pkg::FUNC_LOGIC: begin
                if (i_item.logic_op == ibx_pkg::LOP_BAD) begin
                    o_res.status  = ibx_pkg::STATUS_ERR;
                    o_res.next_pc = i_pc;
                end else begin
                    wval = lres;
                    if (setf) begin
                        o_res.nzcv = {(w64 ? lres[63] : lres[31]), (lres == '0), 2'b00};
                    end
                    gp_en = (i_item.dest_reg != ibx_pkg::REG_ZR);
                end
            end
            default: begin
                o_res.status  = ibx_pkg::STATUS_ERR;
                o_res.next_pc = i_pc;
            end
        endcase

        if (gp_en) begin
            o_res.dest_kind  = ibx_pkg::KIND_GP;
            o_res.dest_index = widx;
            o_res.dest_value = ibx_pkg::fit(wval, wfit);
        end else if (sp_en) begin
            o_res.dest_kind  = ibx_pkg::KIND_SP;
            o_res.dest_index = '0;
            o_res.dest_value = ibx_pkg::fit(wval, wfit);
        end else begin
            o_res.dest_kind  = ibx_pkg::KIND_NONE;
            o_res.dest_index = '0;
            o_res.dest_value = '0;
        end
    end

endmodule

### hw/rtl/arm64_integer_branch_execute_unit_core.sv
// Top level of the integer/branch execute unit: item and result registers,
// architectural state (PC, SP, NZCV) and handshakes. Uses ibx_pkg, ibx_regfile, ibx_exec.
//
//  channel | dir | tdata / tuser contents                       | accept
//  --------+-----+----------------------------------------------+---------------------
//  s_axis  | in  | micro-op fields / func                       | tvalid & tready
//  m_axis  | out | next_pc, dest_index, dest_value, nzcv / kind | tvalid & tready
//
// One micro-op per cycle sustained while m_axis is not stalled; the register file is read
// as a request enters the item register, and it is executed into the result register
// once that register is free or draining. Architectural state commits when the result
// register loads, so back-to-back dependent requests see it through the register-file
// bypass.
// Reset clears PC, SP, NZCV and every general register (via valid bits).
// A stalled result holds the item register; input is refused only when both are full.
module arm64_integer_branch_execute_unit_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [4:0] dest_reg, [9:5] src_reg_a, [14:10] src_reg_b, [22:15] op_flags,
    // [28:23] amount, [30:29] logic_op, [34:31] cond_or_shift, [98:35] immediate
    input  logic [ibx_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // [2:0] func
    input  logic [ibx_pkg::S_TUSER_W-1:0]   i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [63:0] next_pc, [68:64] dest_index, [132:69] dest_value, [136:133] nzcv
    output logic [ibx_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    // [1:0] dest_kind, [2] status
    output logic [ibx_pkg::M_TUSER_W-1:0]   o_m_axis_tuser
);

    ibx_pkg::t_item           n_item, r_item;
    ibx_pkg::t_result         exec_res, r_res;
    ibx_pkg::t_rf_read        rf_rd;
    ibx_pkg::t_rf_write       rf_wr;
    logic                     r_in_valid, r_out_valid;
    logic [ibx_pkg::XLEN-1:0] r_pc, r_sp;
    logic [3:0]               r_nzcv;
    logic [ibx_pkg::XLEN-1:0] reg_a, reg_b;
    logic                     s_accept, advance;

    always_comb begin
        n_item.func          = ibx_pkg::t_func'(i_s_axis_tuser[2:0]);
        n_item.dest_reg      = i_s_axis_tdata[4:0];
        n_item.src_reg_a     = i_s_axis_tdata[9:5];
        n_item.src_reg_b     = i_s_axis_tdata[14:10];
        n_item.op_flags      = i_s_axis_tdata[22:15];
        n_item.amount        = i_s_axis_tdata[28:23];
        n_item.logic_op      = ibx_pkg::t_logic_op'(i_s_axis_tdata[30:29]);
        n_item.cond_or_shift = i_s_axis_tdata[34:31];
        n_item.immediate     = i_s_axis_tdata[98:35];
    end

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Move-wide keep reads the destination on port A
    assign rf_rd.re     = s_accept;
    assign rf_rd.addr_a = (n_item.func == ibx_pkg::FUNC_MOVW) ? n_item.dest_reg
                                                              : n_item.src_reg_a;
    assign rf_rd.addr_b = n_item.src_reg_b;

    assign rf_wr.we   = advance && (exec_res.dest_kind == ibx_pkg::KIND_GP);
    assign rf_wr.addr = exec_res.dest_index;
    assign rf_wr.data = exec_res.dest_value;

    ibx_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd      (rf_rd),
        .i_wr      (rf_wr),
        .o_rdata_a (reg_a),
        .o_rdata_b (reg_b)
    );

    ibx_exec u_exec (
        .i_item  (r_item),
        .i_reg_a (reg_a),
        .i_reg_b (reg_b),
        .i_pc    (r_pc),
        .i_sp    (r_sp),
        .i_nzcv  (r_nzcv),
        .o_res   (exec_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pc        <= '0;
            r_sp        <= '0;
            r_nzcv      <= '0;
        end else begin
            if (s_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            // Commit architectural state as the result is registered
            if (advance) begin
                r_pc   <= exec_res.next_pc;
                r_nzcv <= exec_res.nzcv;
                if (exec_res.dest_kind == ibx_pkg::KIND_SP) begin
                    r_sp <= exec_res.dest_value;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_item <= n_item;
        end
        if (advance) begin
            r_res <= exec_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_res.nzcv, r_res.dest_value, r_res.dest_index,
                              r_res.next_pc};
    assign o_m_axis_tuser  = {r_res.status, r_res.dest_kind};

`ifndef SYNTHESIS
    a_err_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && exec_res.status == ibx_pkg::STATUS_ERR)
            |-> (exec_res.dest_kind == ibx_pkg::KIND_NONE))
        else $error("rejected request writes a destination");

    a_err_pc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && exec_res.status == ibx_pkg::STATUS_ERR)
            |=> (r_pc == $past(r_pc) && r_nzcv == $past(r_nzcv)))
        else $error("rejected request changed pc or flags");

    a_item_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_item)))
        else $error("held request lost or overwritten");

    a_index_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.dest_kind != ibx_pkg::KIND_GP)
            |-> (r_res.dest_index == '0))
        else $error("dest_index set without a general register write");
`endif

endmodule

### bench/arm64_integer_branch_execute_unit_core_tb.sv
// Self-checking bench for arm64_integer_branch_execute_unit_core: a short list of directed
// micro-ops, then random ones under several idle/stall mixes, checked against a local model.
// Depends on ibx_pkg and the unit's RTL only.
module arm64_integer_branch_execute_unit_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // func codes the unit does not implement
    localparam logic [2:0] FUNC_RSVD6 = 3'd6;
    localparam logic [2:0] FUNC_RSVD7 = 3'd7;

    localparam logic [7:0] OPF_W64  = 8'(1 << ibx_pkg::FL_W64);
    localparam logic [7:0] OPF_SUB  = 8'(1 << ibx_pkg::FL_SUB);
    localparam logic [7:0] OPF_SETF = 8'(1 << ibx_pkg::FL_SETF);
    localparam logic [7:0] OPF_REG  = 8'(1 << ibx_pkg::FL_REG);
    localparam logic [7:0] OPF_MOVN = 8'(1 << ibx_pkg::FL_MOVN);
    localparam logic [7:0] OPF_INV  = 8'(1 << ibx_pkg::FL_INV);

    localparam logic signed [63:0] IMM_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam logic signed [63:0] IMM_MIN = 64'sh8000_0000_0000_0000;

    typedef struct {
        ibx_pkg::t_item   op;
        bit               typed;
        ibx_pkg::t_result want;
    } t_uop_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_s_axis_tvalid = 1'b0;
    logic                          o_s_axis_tready;
    logic [ibx_pkg::S_TDATA_W-1:0] i_s_axis_tdata = '0;
    logic [ibx_pkg::S_TUSER_W-1:0] i_s_axis_tuser = '0;
    logic                          o_m_axis_tvalid;
    logic                          i_m_axis_tready = 1'b0;
    logic [ibx_pkg::M_TDATA_W-1:0] o_m_axis_tdata;
    logic [ibx_pkg::M_TUSER_W-1:0] o_m_axis_tuser;

    // architectural state as the bench sees it
    logic [63:0] arch_gp [0:30];
    logic [63:0] arch_sp;
    logic [63:0] arch_pc;
    logic [3:0]  arch_nzcv;

    // register write made by the micro-op being predicted
    ibx_pkg::t_dest_kind wr_kind;
    logic [4:0]          wr_index;
    logic [63:0]         wr_value;

    ibx_pkg::t_result pending_results [$];
    t_uop_row         directed [$];
    int               fail_count = 0;
    int               gap_pct = 0;
    int               stall_pct = 0;

    arm64_integer_branch_execute_unit_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [63:0] word_trim(logic [63:0] v, logic w64);
        return w64 ? v : {32'd0, v[31:0]};
    endfunction

    function automatic logic [63:0] read_zero(logic [4:0] r, logic w64);
        return (r == ibx_pkg::REG_ZR) ? 64'd0 : word_trim(arch_gp[r], w64);
    endfunction

    function automatic logic [63:0] read_stack(logic [4:0] r, logic w64);
        return word_trim((r == ibx_pkg::REG_ZR) ? arch_sp : arch_gp[r], w64);
    endfunction

    function automatic void store_gp(logic [4:0] r, logic w64, logic [63:0] v);
        if (r == ibx_pkg::REG_ZR)
            return;
        arch_gp[r] = word_trim(v, w64);
        wr_kind  = ibx_pkg::KIND_GP;
        wr_index = r;
        wr_value = arch_gp[r];
    endfunction

    function automatic void store_sp(logic [4:0] r, logic w64, logic [63:0] v);
        if (r == ibx_pkg::REG_ZR) begin
            arch_sp  = word_trim(v, w64);
            wr_kind  = ibx_pkg::KIND_SP;
            wr_index = 5'd0;
            wr_value = arch_sp;
        end else begin
            store_gp(r, w64, v);
        end
    endfunction

    function automatic bit cond_met(logic [3:0] c);
        logic n, z, cy, v;
        {n, z, cy, v} = arch_nzcv;
        case (c)
            ibx_pkg::COND_EQ: return z;
            ibx_pkg::COND_NE: return !z;
            ibx_pkg::COND_CS: return cy;
            ibx_pkg::COND_CC: return !cy;
            ibx_pkg::COND_MI: return n;
            ibx_pkg::COND_PL: return !n;
            ibx_pkg::COND_VS: return v;
            ibx_pkg::COND_VC: return !v;
            ibx_pkg::COND_HI: return cy && !z;
            ibx_pkg::COND_LS: return !cy || z;
            ibx_pkg::COND_GE: return n == v;
            ibx_pkg::COND_LT: return n != v;
            ibx_pkg::COND_GT: return !z && (n == v);
            ibx_pkg::COND_LE: return z || (n != v);
            default: return 1'b1;
        endcase
    endfunction

    function automatic logic [63:0] shifted(logic [63:0] v, logic [3:0] typ, logic [5:0] amt,
                                            logic w64);
        int unsigned width = w64 ? 64 : 32;
        logic [63:0] mask  = w64 ? '1 : ibx_pkg::MASK32;
        logic        neg;
        int unsigned n;
        v   = v & mask;
        neg = w64 ? v[63] : v[31];
        case (typ)
            ibx_pkg::SH_LSL: return (amt >= width) ? 64'd0 : ((v << amt) & mask);
            ibx_pkg::SH_LSR: return (amt >= width) ? 64'd0 : (v >> amt);
            ibx_pkg::SH_ASR: begin
                if (amt >= width)
                    return neg ? mask : 64'd0;
                if (neg && amt != 0)
                    return (v >> amt) | ((mask << (width - amt)) & mask);
                return v >> amt;
            end
            ibx_pkg::SH_ROR: begin
                n = amt % width;
                if (n == 0)
                    return v;
                return ((v >> n) | (v << (width - n))) & mask;
            end
            default: return v;
        endcase
    endfunction

    // Execute one micro-op on the bench state and return the result it should give
    function automatic ibx_pkg::t_result execute_uop(ibx_pkg::t_item u);
        ibx_pkg::t_result res;
        logic             w64;
        logic             is_sub;
        logic [63:0]      sgn;
        logic [63:0]      l, r, acc, m;
        logic [3:0]       f;
        logic             st;

        w64      = u.op_flags[ibx_pkg::FL_W64];
        is_sub   = u.op_flags[ibx_pkg::FL_SUB];
        sgn      = w64 ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
        st       = ibx_pkg::STATUS_OK;
        wr_kind  = ibx_pkg::KIND_NONE;
        wr_index = 5'd0;
        wr_value = 64'd0;

        case (u.func)
            ibx_pkg::FUNC_ADDSUB: begin
                if (u.op_flags[ibx_pkg::FL_REG]) begin
                    l = read_zero(u.src_reg_a, w64);
                    r = read_zero(u.src_reg_b, w64);
                end else begin
                    l = read_stack(u.src_reg_a, w64);
                    r = word_trim(u.immediate, w64);
                end
                acc = word_trim(is_sub ? l - r : l + r, w64);
                if (u.op_flags[ibx_pkg::FL_SETF]) begin
                    f[3] = (acc & sgn) != 0;
                    f[2] = acc == 0;
                    f[1] = is_sub ? (l >= r) : (acc < l);
                    f[0] = is_sub ? (((l ^ r) & (l ^ acc) & sgn) != 0)
                                  : ((~(l ^ r) & (l ^ acc) & sgn) != 0);
                    arch_nzcv = f;
                    store_gp(u.dest_reg, w64, acc);
                end else begin
                    store_sp(u.dest_reg, w64, acc);
                end
                arch_pc += ibx_pkg::PC_STEP;
            end
            ibx_pkg::FUNC_BCOND:
                arch_pc += cond_met(u.cond_or_shift) ? u.immediate : ibx_pkg::PC_STEP;
            ibx_pkg::FUNC_CBZ:
                arch_pc += ((read_zero(u.src_reg_b, w64) == 0) != u.op_flags[ibx_pkg::FL_REG])
                           ? u.immediate : ibx_pkg::PC_STEP;
            ibx_pkg::FUNC_B: begin
                if (u.op_flags[ibx_pkg::FL_REG])
                    store_gp(ibx_pkg::REG_LINK, 1'b1, arch_pc + ibx_pkg::PC_STEP);
                arch_pc += u.immediate;
            end
            ibx_pkg::FUNC_MOVW: begin
                // MOVK wins over MOVN when both are set
                if (u.op_flags[ibx_pkg::FL_REG]) begin
                    m   = ibx_pkg::HALF_MASK << u.amount;
                    acc = (read_zero(u.dest_reg, w64) & ~m) | u.immediate;
                end else if (u.op_flags[ibx_pkg::FL_MOVN]) begin
                    acc = ~u.immediate;
                end else begin
                    acc = u.immediate;
                end
                store_gp(u.dest_reg, w64, acc);
                arch_pc += ibx_pkg::PC_STEP;
            end
            ibx_pkg::FUNC_LOGIC: begin
                if (u.logic_op == ibx_pkg::LOP_BAD) begin
                    st = ibx_pkg::STATUS_ERR;
                end else begin
                    l = read_zero(u.src_reg_a, w64);
                    r = shifted(read_zero(u.src_reg_b, w64), u.cond_or_shift, u.amount, w64);
                    if (u.op_flags[ibx_pkg::FL_INV])
                        r = ~r;
                    case (u.logic_op)
                        ibx_pkg::LOP_AND: acc = l & r;
                        ibx_pkg::LOP_ORR: acc = l | r;
                        default: acc = l ^ r;
                    endcase
                    acc = word_trim(acc, w64);
                    if (u.op_flags[ibx_pkg::FL_SETF])
                        arch_nzcv = {(acc & sgn) != 0, acc == 0, 2'b00};
                    store_gp(u.dest_reg, w64, acc);
                    arch_pc += ibx_pkg::PC_STEP;
                end
            end
            default: st = ibx_pkg::STATUS_ERR;
        endcase

        res.next_pc    = arch_pc;
        res.dest_kind  = wr_kind;
        res.dest_index = wr_index;
        res.dest_value = wr_value;
        res.nzcv       = arch_nzcv;
        res.status     = st;
        return res;
    endfunction

    function automatic ibx_pkg::t_item mk(logic [2:0] fn, logic [4:0] rd, logic [4:0] ra,
                                          logic [4:0] rb, logic [7:0] fl, logic [5:0] amt,
                                          logic [1:0] lop, logic [3:0] cs,
                                          logic signed [63:0] imm);
        ibx_pkg::t_item u;
        u.func          = ibx_pkg::t_func'(fn);
        u.dest_reg      = rd;
        u.src_reg_a     = ra;
        u.src_reg_b     = rb;
        u.op_flags      = fl;
        u.amount        = amt;
        u.logic_op      = ibx_pkg::t_logic_op'(lop);
        u.cond_or_shift = cs;
        u.immediate     = imm;
        return u;
    endfunction

    function automatic ibx_pkg::t_result outcome(logic [63:0] pc, ibx_pkg::t_dest_kind kind,
                                                 logic [4:0] idx, logic [63:0] val,
                                                 logic [3:0] flags, logic st);
        ibx_pkg::t_result res;
        res.next_pc    = pc;
        res.dest_kind  = kind;
        res.dest_index = idx;
        res.dest_value = val;
        res.nzcv       = flags;
        res.status     = st;
        return res;
    endfunction

    function automatic logic [4:0] draw_reg();
        int unsigned k;
        if ($urandom_range(1))
            return 5'($urandom_range(31));
        // favour a few registers so that results feed later requests
        k = $urandom_range(3);
        return (k == 3) ? ibx_pkg::REG_ZR : 5'(k);
    endfunction

    function automatic ibx_pkg::t_item random_uop();
        ibx_pkg::t_item u;
        int             s;
        int unsigned    pick;
        pick = $urandom_range(99);
        if (pick < 4)
            u.func = ibx_pkg::t_func'((pick < 2) ? FUNC_RSVD6 : FUNC_RSVD7);
        else
            u.func = ibx_pkg::t_func'($urandom_range(5));
        u.dest_reg  = draw_reg();
        u.src_reg_a = draw_reg();
        u.src_reg_b = draw_reg();
        u.op_flags  = 8'($urandom_range(255));
        u.amount    = 6'($urandom_range(63));
        u.logic_op  = ($urandom_range(9) == 0) ? ibx_pkg::LOP_BAD
                                               : ibx_pkg::t_logic_op'($urandom_range(2));
        if (u.func == ibx_pkg::FUNC_LOGIC && $urandom_range(3) != 0)
            u.cond_or_shift = 4'($urandom_range(3));
        else
            u.cond_or_shift = 4'($urandom_range(15));
        case ($urandom_range(3))
            0: u.immediate = {$urandom, $urandom};
            1: begin
                s = $urandom_range(128);
                u.immediate = 64'(s - 64);
            end
            2: case ($urandom_range(3))
                0: u.immediate = 64'sd0;
                1: u.immediate = -64'sd1;
                2: u.immediate = IMM_MIN;
                default: u.immediate = IMM_MAX;
            endcase
            default: u.immediate = ({$urandom, $urandom} & ibx_pkg::HALF_MASK)
                                   << (16 * $urandom_range(3));
        endcase
        return u;
    endfunction

    task automatic issue_uop(input ibx_pkg::t_item u, input bit typed,
                             input ibx_pkg::t_result want);
        ibx_pkg::t_result pred;
        // idle the sender for a random number of cycles before the request
        while ($urandom_range(99) < gap_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {5'd0, u.immediate, u.cond_or_shift, u.logic_op, u.amount,
                            u.op_flags, u.src_reg_b, u.src_reg_a, u.dest_reg};
        i_s_axis_tuser  <= u.func;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pred = execute_uop(u);
        pending_results.push_back(typed ? want : pred);
    endtask

    // Hold off new requests until every outstanding result is back
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic random_run(input int count);
        for (int i = 0; i < count; i++)
            issue_uop(random_uop(), 1'b0, '0);
        settle();
    endtask

    always @(posedge i_clk)
        i_m_axis_tready <= ($urandom_range(99) >= stall_pct);

    function automatic void note_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %h, got %h", name, exp_v, got_v);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        ibx_pkg::t_result got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.next_pc    = o_m_axis_tdata[63:0];
            got.dest_index = o_m_axis_tdata[68:64];
            got.dest_value = o_m_axis_tdata[132:69];
            got.nzcv       = o_m_axis_tdata[136:133];
            got.dest_kind  = ibx_pkg::t_dest_kind'(o_m_axis_tuser[1:0]);
            got.status     = o_m_axis_tuser[2];
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: next_pc %h", got.next_pc);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                note_field("next_pc", want.next_pc, got.next_pc);
                note_field("dest_kind", 64'(want.dest_kind), 64'(got.dest_kind));
                note_field("dest_index", 64'(want.dest_index), 64'(got.dest_index));
                note_field("dest_value", want.dest_value, got.dest_value);
                note_field("nzcv", 64'(want.nzcv), 64'(got.nzcv));
                note_field("status", 64'(want.status), 64'(got.status));
            end
        end
    end

    initial begin
        for (int i = 0; i < ibx_pkg::REG_COUNT; i++)
            arch_gp[i] = 64'd0;
        arch_sp   = 64'd0;
        arch_pc   = 64'd0;
        arch_nzcv = 4'd0;

        // Results typed in here follow straight from the cleared state
        directed.push_back('{mk(ibx_pkg::FUNC_ADDSUB, 0, ibx_pkg::REG_ZR, 0, OPF_W64, 0,
            ibx_pkg::LOP_AND, 0, IMM_MAX), 1'b1,
            outcome(64'd4, ibx_pkg::KIND_GP, 5'd0, IMM_MAX, 4'd0, ibx_pkg::STATUS_OK)});
        directed.push_back('{mk(ibx_pkg::FUNC_ADDSUB, 1, 0, 0, OPF_W64 | OPF_SETF, 0,
            ibx_pkg::LOP_AND, 0, 64'sd1), 1'b1,
            outcome(64'd8, ibx_pkg::KIND_GP, 5'd1, IMM_MIN, 4'b1001, ibx_pkg::STATUS_OK)});
        directed.push_back('{mk(ibx_pkg::FUNC_LOGIC, 5, 0, 1, OPF_W64, 0, ibx_pkg::LOP_BAD,
            0, 64'sd0), 1'b1,
            outcome(64'd8, ibx_pkg::KIND_NONE, 5'd0, 64'd0, 4'b1001, ibx_pkg::STATUS_ERR)});
        directed.push_back('{mk(FUNC_RSVD6, 2, 0, 1, OPF_W64, 0, ibx_pkg::LOP_AND, 0, 64'sd4),
            1'b1,
            outcome(64'd8, ibx_pkg::KIND_NONE, 5'd0, 64'd0, 4'b1001, ibx_pkg::STATUS_ERR)});
        directed.push_back('{mk(FUNC_RSVD7, 2, 0, 1, OPF_W64, 0, ibx_pkg::LOP_AND, 0, 64'sd4),
            1'b1,
            outcome(64'd8, ibx_pkg::KIND_NONE, 5'd0, 64'd0, 4'b1001, ibx_pkg::STATUS_ERR)});
        // sub forms: 32-bit flags, write to SP, compare discarding the result
        directed.push_back('{mk(ibx_pkg::FUNC_ADDSUB, 2, 0, 1, OPF_SUB | OPF_SETF | OPF_REG,
            0, ibx_pkg::LOP_AND, 0, 64'sd0), 1'b0, '0});
        directed.push_back('{mk(ibx_pkg::FUNC_ADDSUB, ibx_pkg::REG_ZR, ibx_pkg::REG_ZR, 0,
            OPF_W64 | OPF_SUB, 0, ibx_pkg::LOP_AND, 0, -64'sd1), 1'b0, '0});
        directed.push_back('{mk(ibx_pkg::FUNC_ADDSUB, ibx_pkg::REG_ZR, ibx_pkg::REG_ZR, 1,
            OPF_W64 | OPF_SUB | OPF_SETF | OPF_REG, 0, ibx_pkg::LOP_AND, 0, 64'sd0),
            1'b0, '0});
        directed.push_back('{mk(ibx_pkg::FUNC_BCOND, 0, 0, 0, 0, 0, ibx_pkg::LOP_AND,
            ibx_pkg::COND_EQ, IMM_MIN), 1'b0, '0});
        directed.push_back('{mk(ibx_pkg::FUNC_BCOND, 0, 0, 0, 0, 0, ibx_pkg::LOP_AND,
            ibx_pkg::COND_AL, 64'sd16), 1'b0, '0});
        directed.push_back('{mk(ibx_pkg::FUNC_BCOND, 0, 0, 0, 0, 0, ibx_pkg::LOP_AND,
            ibx_pkg::COND_NV, -64'sd8), 1'b0, '0});
        directed.push_back('{mk(ibx_pkg::FUNC_CBZ, 0, 0, ibx_pkg::REG_ZR, OPF_W64, 0,
            ibx_pkg::LOP_AND, 0, 64'sd12), 1'b0, '0});
        directed.push_back('{mk(ibx_pkg::FUNC_CBZ, 0, 0, 0, OPF_W64 | OPF_REG, 0,
            ibx_pkg::LOP_AND, 0, -64'sd12), 1'b0, '0});
        directed.push_back('{mk(ibx_pkg::FUNC_B, 0, 0, 0, OPF_REG, 0, ibx_pkg::LOP_AND, 0,
            64'sh100), 1'b0, '0});
        directed.push_back('{mk(ibx_pkg::FUNC_B, 0, 0, 0, 0, 0, ibx_pkg::LOP_AND, 0, -64'sd4),
            1'b0, '0});
        directed.push_back('{mk(ibx_pkg::FUNC_MOVW, 3, 0, 0, OPF_W64, 0, ibx_pkg::LOP_AND, 0,
            64'shffff_0000), 1'b0, '0});
        directed.push_back('{mk(ibx_pkg::FUNC_MOVW, 4, 0, 0, OPF_MOVN, 0, ibx_pkg::LOP_AND, 0,
            64'sd0), 1'b0, '0});
        directed.push_back('{mk(ibx_pkg::FUNC_MOVW, 3, 0, 0, OPF_W64 | OPF_REG, 16,
            ibx_pkg::LOP_AND, 0, 64'sh1234_0000), 1'b0, '0});
        directed.push_back('{mk(ibx_pkg::FUNC_MOVW, ibx_pkg::REG_ZR, 0, 0,
            OPF_W64 | OPF_REG | OPF_MOVN, 48, ibx_pkg::LOP_AND, 0,
            64'shbeef_0000_0000_0000), 1'b0, '0});
        // shifted logical forms, including the out-of-range 32-bit amounts
        directed.push_back('{mk(ibx_pkg::FUNC_LOGIC, 5, 0, 1, OPF_W64 | OPF_SETF, 63,
            ibx_pkg::LOP_AND, ibx_pkg::SH_LSL, 64'sd0), 1'b0, '0});
        directed.push_back('{mk(ibx_pkg::FUNC_LOGIC, 6, 3, 0, 0, 40, ibx_pkg::LOP_ORR,
            ibx_pkg::SH_LSR, 64'sd0), 1'b0, '0});
        directed.push_back('{mk(ibx_pkg::FUNC_LOGIC, 7, 1, 0, OPF_INV, 33, ibx_pkg::LOP_EOR,
            ibx_pkg::SH_ASR, 64'sd0), 1'b0, '0});
        directed.push_back('{mk(ibx_pkg::FUNC_LOGIC, 8, ibx_pkg::REG_ZR, 3, 0, 35,
            ibx_pkg::LOP_ORR, ibx_pkg::SH_ROR, 64'sd0), 1'b0, '0});
        directed.push_back('{mk(ibx_pkg::FUNC_LOGIC, ibx_pkg::REG_ZR, 0, 1, OPF_W64 | OPF_SETF,
            5, ibx_pkg::LOP_AND, 4'd9, 64'sd0), 1'b0, '0});
        directed.push_back('{mk(ibx_pkg::FUNC_LOGIC, 9, 1, 0, OPF_W64 | OPF_SETF | OPF_INV, 0,
            ibx_pkg::LOP_EOR, ibx_pkg::SH_ROR, 64'sd0), 1'b0, '0});
        // arithmetic shift of a 32-bit word by less than its width
        directed.push_back('{mk(ibx_pkg::FUNC_LOGIC, 10, ibx_pkg::REG_ZR, 1, 0, 4,
            ibx_pkg::LOP_ORR, ibx_pkg::SH_ASR, 64'sd0), 1'b0, '0});

        gap_pct   = 15;
        stall_pct = 68;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i])
            issue_uop(directed[i].op, directed[i].typed, directed[i].want);
        settle();
        random_run(350);

        gap_pct   = 68;
        stall_pct = 15;
        random_run(375);

        gap_pct   = 0;
        stall_pct = 0;
        random_run(375);

        // let any stray result show up before judging
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### arm64_integer_branch_execute_unit_core.f
hw/rtl/ibx_pkg.sv
hw/rtl/ibx_ram.sv
hw/rtl/ibx_regfile.sv
hw/rtl/ibx_exec.sv
hw/rtl/arm64_integer_branch_execute_unit_core.sv
bench/arm64_integer_branch_execute_unit_core_tb.sv
